### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/u2u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
`default_nettype none

package u2u8_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW = $clog2(MaxBytes);

  // Surrogate prefixes: top six bits of the code unit.
  localparam logic [5:0] HighSurrPfx = 6'b110110;
  localparam logic [5:0] LowSurrPfx  = 6'b110111;

  // Lead byte markers and the plane offset of a surrogate pair.
  localparam logic [7:0]  Lead2      = 8'hc0;
  localparam logic [7:0]  Lead3      = 8'he0;
  localparam logic [7:0]  Lead4      = 8'hf0;
  localparam logic [7:0]  ContMark   = 8'h80;
  localparam logic [10:0] PlaneOffs  = 11'h040;

  // One encoded job: the bytes to send, index of the final byte, error flag.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
    logic                           err;
  } job_t;

endpackage

`default_nettype wire

### rtl/u2u8_front.sv
// Front end: accepts code units, tracks surrogate state and builds byte jobs.
`timescale 1ns / 1ps
`default_nettype none

module u2u8_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [15:0]   code_unit_i,
  input  wire logic          last_unit_i,
  output u2u8_pkg::job_t     job_o,
  output logic               push_o
);

  logic [9:0]  held_q, held_d;
  logic        pend_q, pend_d;
  logic        drop_q, drop_d;
  logic        is_low, is_high;
  logic [10:0] top;

  assign is_low  = (code_unit_i[15:10] == u2u8_pkg::LowSurrPfx);
  assign is_high = (code_unit_i[15:10] == u2u8_pkg::HighSurrPfx);
  // Bits 20..10 of the supplementary code point.
  assign top     = {1'b0, held_q} + u2u8_pkg::PlaneOffs;

  // Classify the word and encode it.
  always_comb begin
    held_d = held_q;
    pend_d = pend_q;
    drop_d = drop_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept_i) begin
      priority if (drop_q) begin
        if (last_unit_i) drop_d = 1'b0;
      end else if (pend_q) begin
        pend_d = 1'b0;
        push_o = 1'b1;
        if (!is_low) begin
          job_o.err = 1'b1;
          drop_d    = !last_unit_i;
        end else begin
          job_o.bytes[0] = u2u8_pkg::Lead4 | {5'b0, top[10:8]};
          job_o.bytes[1] = u2u8_pkg::ContMark | {2'b0, top[7:2]};
          job_o.bytes[2] = u2u8_pkg::ContMark | {2'b0, top[1:0], code_unit_i[9:6]};
          job_o.bytes[3] = u2u8_pkg::ContMark | {2'b0, code_unit_i[5:0]};
          job_o.last_idx = 2'd3;
        end
      end else if (code_unit_i[15:7] == '0) begin
        push_o         = 1'b1;
        job_o.bytes[0] = {1'b0, code_unit_i[6:0]};
        job_o.last_idx = 2'd0;
      end else if (code_unit_i[15:11] == '0) begin
        push_o         = 1'b1;
        job_o.bytes[0] = u2u8_pkg::Lead2 | {3'b0, code_unit_i[10:6]};
        job_o.bytes[1] = u2u8_pkg::ContMark | {2'b0, code_unit_i[5:0]};
        job_o.last_idx = 2'd1;
      end else if (!is_high) begin
        push_o         = 1'b1;
        job_o.bytes[0] = u2u8_pkg::Lead3 | {4'b0, code_unit_i[15:12]};
        job_o.bytes[1] = u2u8_pkg::ContMark | {2'b0, code_unit_i[11:6]};
        job_o.bytes[2] = u2u8_pkg::ContMark | {2'b0, code_unit_i[5:0]};
        job_o.last_idx = 2'd2;
      end else if (last_unit_i) begin
        // high surrogate ends the string
        push_o    = 1'b1;
        job_o.err = 1'b1;
      end else begin
        held_d = code_unit_i[9:0];
        pend_d = 1'b1;
      end
    end
  end

  // Surrogate and discard state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pend_q <= 1'b0;
      drop_q <= 1'b0;
    end else begin
      held_q <= held_d;
      pend_q <= pend_d;
      drop_q <= drop_d;
    end
  end

endmodule

`default_nettype wire

### rtl/u2u8_fifo.sv
// Small job queue between the front end and the byte sender.
`timescale 1ns / 1ps
`default_nettype none

module u2u8_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  u2u8_pkg::job_t      job_i,
  input  wire logic           pop_i,
  output u2u8_pkg::job_t      job_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  u2u8_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/u2u8_back.sv
// Byte sender: takes jobs from the queue and drives one byte per word.
`timescale 1ns / 1ps
`default_nettype none

module u2u8_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  u2u8_pkg::job_t     job_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_byte_o,
  output logic               bad_sequence_o
);

  u2u8_pkg::job_t              job_q;
  logic [u2u8_pkg::IdxW-1:0]   idx_q;
  logic                        busy_q;
  logic                        out_take, at_end;

  assign out_take = busy_q && !out_stall_i;
  assign at_end   = (idx_q == job_q.last_idx);
  // Load the next job when idle or when the final byte leaves.
  assign pop_o    = !empty_i && (!busy_q || (out_take && at_end));

  assign out_valid_o    = busy_q;
  assign out_byte_o     = job_q.bytes[idx_q];
  assign last_byte_o    = at_end;
  assign bad_sequence_o = job_q.err;

  // Current job payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
  end

  // Byte index and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else if (pop_o) begin
      idx_q  <= '0;
      busy_q <= 1'b1;
    end else if (out_take) begin
      if (at_end) busy_q <= 1'b0;
      else        idx_q  <= idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder top level.
// Accepts one code unit word per cycle while the job queue has room.
// Jobs pass the queue into the sender's register; bytes leave one per cycle unless stalled.
// A unit yields 1 to 4 bytes, and new units can be taken while the byte sender is busy.
// Units that produce no byte (held high surrogate, discarded unit) push no job.
// Reset: asynchronous active low; clears surrogate state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none

module utf16_to_utf8_encoder #(
  parameter int unsigned FifoDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] code_unit_i,
  input  wire logic        last_unit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_byte_o,
  output logic             bad_sequence_o
);

  u2u8_pkg::job_t front_job, queue_job;
  logic           push, pop, empty, full, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .job_o       (front_job),
    .push_o      (push)
  );

  u2u8_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (queue_job),
    .empty_o (empty),
    .full_o  (full)
  );

  u2u8_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (queue_job),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o),
    .bad_sequence_o (bad_sequence_o)
  );

endmodule

`default_nettype wire

### rtl/u2u8_checker.sv
// Port-level checker for the encoder and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module u2u8_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        last_byte_o,
  input wire logic        bad_sequence_o
);

  logic       err_word, err_ok, mid_word, mid_take, cont_ok, out_held;
  logic [9:0] out_word;

  assign err_word = out_valid_o && bad_sequence_o;
  assign err_ok   = (out_byte_o == 8'h00) && last_byte_o;
  assign mid_word = out_valid_o && !last_byte_o;
  assign mid_take = mid_word && !out_stall_i;
  assign cont_ok  = out_valid_o && (out_byte_o[7:6] == 2'b10) && !bad_sequence_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {out_byte_o, last_byte_o, bad_sequence_o};

  // error word carries a zero byte and closes its group
  `ASSERT_ALWAYS(a_err_shape, clk_i, rst_ni, !err_word || err_ok, "error word malformed")
  // a non-final byte is always a lead or continuation byte
  `ASSERT_ALWAYS(a_mid_high, clk_i, rst_ni, !mid_word || out_byte_o[7], "non-final byte low")
  // after a non-final byte leaves, a continuation byte follows at once
  `ASSERT_NEXT(a_cont, clk_i, rst_ni, mid_take, cont_ok, "continuation byte missing")
  // a stalled output word holds
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word), "word changed")

endmodule

bind utf16_to_utf8_encoder u2u8_checker u_checker (.*);

`default_nettype wire
